### src/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Types and constants shared by the text encoding sniffer modules.
// ----------------------------------------------------------------------------
package tes_pkg;

  // one byte of the file, with its valid and end of file markers
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_file;
  } in_t;

  // verdict for one file
  typedef struct packed {
    logic [2:0] encoding_kind;
    logic       is_binary;
    logic       has_non_ascii;
    logic       is_utf8;
    logic       is_utf16;
  } out_t;

  typedef enum logic [2:0] {
    KIND_EMPTY   = 3'd0,
    KIND_UTF8    = 3'd1,
    KIND_UTF16LE = 3'd2,
    KIND_UTF16BE = 3'd3,
    KIND_UTF32BE = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  // byte order mark bytes
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;
  localparam logic [7:0] BOM16_FF = 8'hFF;
  localparam logic [7:0] BOM16_FE = 8'hFE;
  localparam logic [31:0] BOM32_BE = 32'h0000_FEFF;

endpackage

### src/tes_verdict.sv
// ----------------------------------------------------------------------------
// tes_verdict
// Combinational verdict from the sample statistics of one file.
// ----------------------------------------------------------------------------
module tes_verdict #(
  parameter int CNT_W = 13
) (
  input  logic [31:0]      head,
  input  logic [CNT_W-1:0] seen,
  input  logic [CNT_W-1:0] even_zero,
  input  logic [CNT_W-1:0] odd_zero,
  input  logic [CNT_W-1:0] ctrl_cnt,
  input  logic             null_seen,
  input  logic             high_seen,
  output tes_pkg::out_t    verdict
);
  import tes_pkg::*;

  localparam int MUL_W = CNT_W + 6;

  logic [7:0]       b0, b1, b2;
  logic [MUL_W-1:0] n_w;
  logic             empty, bom8, le_bom, be_bom, le_guess, be_guess, utf32, ctrl_heavy;

  assign b0  = head[31:24];
  assign b1  = head[23:16];
  assign b2  = head[15:8];
  assign n_w = MUL_W'(seen);

  assign empty  = (seen == '0);
  assign bom8   = (seen >= CNT_W'(3)) && (b0 == BOM8_B0) && (b1 == BOM8_B1) &&
                  (b2 == BOM8_B2);
  assign le_bom = (seen >= CNT_W'(2)) && (b0 == BOM16_FF) && (b1 == BOM16_FE);
  assign be_bom = (seen >= CNT_W'(2)) && (b0 == BOM16_FE) && (b1 == BOM16_FF);
  assign utf32  = (seen >= CNT_W'(4)) && (head == BOM32_BE);

  // x > floor(n/6) is 6x > n; x < floor(n/30) is 30(x+1) <= n
  assign le_guess = (MUL_W'(odd_zero) * MUL_W'(6) > n_w) &&
                    ((MUL_W'(even_zero) + MUL_W'(1)) * MUL_W'(30) <= n_w);
  assign be_guess = (MUL_W'(even_zero) * MUL_W'(6) > n_w) &&
                    ((MUL_W'(odd_zero) + MUL_W'(1)) * MUL_W'(30) <= n_w);

  assign ctrl_heavy = (MUL_W'(ctrl_cnt) * MUL_W'(10)) > (n_w * MUL_W'(3));

  always_comb begin
    verdict = '0;
    if (empty) begin
      verdict.encoding_kind = KIND_EMPTY;
      verdict.is_utf8       = 1'b1;
    end else begin
      if (bom8) begin
        verdict.encoding_kind = KIND_UTF8;
        verdict.is_utf8       = 1'b1;
      end else if (le_bom) begin
        verdict.encoding_kind = KIND_UTF16LE;
        verdict.is_utf16      = 1'b1;
      end else if (be_bom) begin
        verdict.encoding_kind = KIND_UTF16BE;
        verdict.is_utf16      = 1'b1;
      end else if (le_guess) begin
        verdict.encoding_kind = KIND_UTF16LE;
        verdict.is_utf16      = 1'b1;
      end else if (be_guess) begin
        verdict.encoding_kind = KIND_UTF16BE;
        verdict.is_utf16      = 1'b1;
      end else if (utf32) begin
        verdict.encoding_kind = KIND_UTF32BE;
      end else begin
        verdict.encoding_kind = KIND_UNKNOWN;
      end
      verdict.has_non_ascii = high_seen;
      verdict.is_binary     = !verdict.is_utf16 && (null_seen || ctrl_heavy);
    end
  end

endmodule

### src/text_encoding_sniffer_core.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_core
// Byte-at-a-time encoding sniffer: byte order marks, UTF-16 zero pattern
// guess and binary detection, one verdict per file at end of file.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload        | handshake
//  --------+-----+----------------+---------------------------
//  in_     | in  | tes_pkg::in_t  | in_valid / in_ready
//  out_    | out | tes_pkg::out_t | out_valid / out_ready
//
//  one transaction per cycle on the input while no end of file item waits;
//  every item passes through the input register, where the statistics
//  update and the verdict are worked out combinationally
//  the verdict is loaded into the output register as the end of file item
//  leaves the input register, when the output register is free or emptying
//  synchronous active-low reset clears the counters and both valid flags
//  only an end of file item waits on a full output register; other items
//  keep flowing while a verdict is held
//
module text_encoding_sniffer_core #(
  parameter int SAMPLE_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tes_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tes_pkg::out_t out_data
);
  import tes_pkg::*;

  // counters hold up to the sample size itself
  localparam int CNT_W = $clog2(SAMPLE_BYTES + 1);
  localparam logic [CNT_W-1:0] SAMPLE_LIM = CNT_W'(SAMPLE_BYTES);

  // input register
  in_t  item_r;
  logic item_valid_r;
  logic item_go;

  // sample statistics
  logic [31:0]      head_r,      head_nxt,      head_upd;
  logic [CNT_W-1:0] seen_r,      seen_nxt,      seen_upd;
  logic [CNT_W-1:0] even_zero_r, even_zero_nxt, even_zero_upd;
  logic [CNT_W-1:0] odd_zero_r,  odd_zero_nxt,  odd_zero_upd;
  logic [CNT_W-1:0] ctrl_r,      ctrl_nxt,      ctrl_upd;
  logic             null_r,      null_nxt,      null_upd;
  logic             high_r,      high_nxt,      high_upd;

  // output register
  out_t out_r;
  logic out_valid_r, out_valid_nxt;
  out_t verdict;

  logic [7:0] b;
  logic       in_sample, is_ctrl;

  // an end of file item needs the output register free (or emptying)
  assign item_go  = item_valid_r && (!item_r.end_of_file || !out_valid_r || out_ready);
  assign in_ready = !item_valid_r || item_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  // ---- statistics update for the byte in the input register ----
  assign b         = item_r.data_byte;
  assign in_sample = item_r.byte_valid && (seen_r < SAMPLE_LIM);

  // control bytes: below space except tab, lf, cr and nul, plus del
  always_comb begin
    is_ctrl = (b inside {[8'h01:8'h08], 8'h0B, 8'h0C, [8'h0E:8'h1F], 8'h7F});
  end

  always_comb begin
    head_upd      = head_r;
    seen_upd      = seen_r;
    even_zero_upd = even_zero_r;
    odd_zero_upd  = odd_zero_r;
    ctrl_upd      = ctrl_r;
    null_upd      = null_r;
    high_upd      = high_r;
    if (in_sample) begin
      // first four bytes land msb first
      if (seen_r < CNT_W'(4)) begin
        head_upd = head_r | ({24'd0, b} << {(2'd3 - seen_r[1:0]), 3'd0});
      end
      if (b == 8'h00) begin
        null_upd = 1'b1;
        if (seen_r[0]) begin
          odd_zero_upd = odd_zero_r + CNT_W'(1);
        end else begin
          even_zero_upd = even_zero_r + CNT_W'(1);
        end
      end else if (is_ctrl) begin
        ctrl_upd = ctrl_r + CNT_W'(1);
      end
      if (b[7]) begin
        high_upd = 1'b1;
      end
      seen_upd = seen_r + CNT_W'(1);
    end
  end

  // verdict from the statistics including this item's byte
  tes_verdict #(
    .CNT_W(CNT_W)
  ) u_verdict (
    .head      (head_upd),
    .seen      (seen_upd),
    .even_zero (even_zero_upd),
    .odd_zero  (odd_zero_upd),
    .ctrl_cnt  (ctrl_upd),
    .null_seen (null_upd),
    .high_seen (high_upd),
    .verdict   (verdict)
  );

  // end of file restarts the statistics for the next file
  always_comb begin
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    even_zero_nxt = even_zero_r;
    odd_zero_nxt  = odd_zero_r;
    ctrl_nxt      = ctrl_r;
    null_nxt      = null_r;
    high_nxt      = high_r;
    if (item_go) begin
      if (item_r.end_of_file) begin
        head_nxt      = '0;
        seen_nxt      = '0;
        even_zero_nxt = '0;
        odd_zero_nxt  = '0;
        ctrl_nxt      = '0;
        null_nxt      = 1'b0;
        high_nxt      = 1'b0;
      end else begin
        head_nxt      = head_upd;
        seen_nxt      = seen_upd;
        even_zero_nxt = even_zero_upd;
        odd_zero_nxt  = odd_zero_upd;
        ctrl_nxt      = ctrl_upd;
        null_nxt      = null_upd;
        high_nxt      = high_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      seen_r      <= '0;
      even_zero_r <= '0;
      odd_zero_r  <= '0;
      ctrl_r      <= '0;
      null_r      <= 1'b0;
      high_r      <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      seen_r      <= seen_nxt;
      even_zero_r <= even_zero_nxt;
      odd_zero_r  <= odd_zero_nxt;
      ctrl_r      <= ctrl_nxt;
      null_r      <= null_nxt;
      high_r      <= high_nxt;
    end
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (item_go && item_r.end_of_file) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && item_r.end_of_file) begin
      out_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### tb/text_encoding_sniffer_core_test.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_core_test
// Streams files byte by byte into the sniffer and checks every verdict
// against a cycle-free model of the byte statistics, under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_encoding_sniffer_core_test;
  import tes_pkg::*;

  localparam int SAMPLE_BYTES = 4096;
  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 14;
  localparam int DRAIN_CYCLES = 8;

  // byte classes used by the model statistics and the text byte generator
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TILDE = 8'h7E;
  localparam logic [7:0] CHR_DEL   = 8'h7F;
  localparam logic [7:0] CHR_HIGH  = 8'h80;

  typedef logic [7:0] byte_q_t[$];

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  // shared switch: when low neither side inserts idle cycles
  bit    idling = 1'b1;
  int    error_count;
  int    file_index;
  int    items_sent;

  // expected verdicts, oldest first
  out_t  pending_verdicts[$];

  // model copy of the sniffer statistics
  logic [31:0] head_bytes;
  int          sampled;
  int          zeros_even;
  int          zeros_odd;
  int          ctrl_bytes;
  bit          saw_null;
  bit          saw_high;

  text_encoding_sniffer_core #(
    .SAMPLE_BYTES(SAMPLE_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // model of the statistics and the verdict
  // ---------------------------------------------------------------------------
  task automatic clear_stats();
    head_bytes = '0;
    sampled    = 0;
    zeros_even = 0;
    zeros_odd  = 0;
    ctrl_bytes = 0;
    saw_null   = 1'b0;
    saw_high   = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (sampled >= SAMPLE_BYTES) return;
    if (sampled < 4) head_bytes[8 * (3 - sampled) +: 8] = b;
    if (b == CHR_NUL) begin
      saw_null = 1'b1;
      if ((sampled % 2) == 0) zeros_even++;
      else zeros_odd++;
    end else if ((b < CHR_SPACE && b != CHR_TAB && b != CHR_LF && b != CHR_CR) ||
                 b == CHR_DEL) begin
      ctrl_bytes++;
    end
    if (b >= CHR_HIGH) saw_high = 1'b1;
    sampled++;
  endtask

  function automatic out_t predict_verdict();
    out_t       v;
    logic [7:0] b0, b1, b2;
    bit         decided;
    v               = '0;
    v.encoding_kind = KIND_UNKNOWN;
    b0              = head_bytes[31:24];
    b1              = head_bytes[23:16];
    b2              = head_bytes[15:8];
    if (sampled == 0) begin
      v.encoding_kind = KIND_EMPTY;
      v.is_utf8       = 1'b1;
    end else begin
      decided = 1'b1;
      if (sampled >= 3 && b0 == BOM8_B0 && b1 == BOM8_B1 && b2 == BOM8_B2) begin
        v.encoding_kind = KIND_UTF8;
        v.is_utf8       = 1'b1;
      end else if (sampled >= 2 && b0 == BOM16_FF && b1 == BOM16_FE) begin
        v.encoding_kind = KIND_UTF16LE;
        v.is_utf16      = 1'b1;
      end else if (sampled >= 2 && b0 == BOM16_FE && b1 == BOM16_FF) begin
        v.encoding_kind = KIND_UTF16BE;
        v.is_utf16      = 1'b1;
      end else if (zeros_odd > sampled / 6 && zeros_even < sampled / 30) begin
        v.encoding_kind = KIND_UTF16LE;
        v.is_utf16      = 1'b1;
      end else if (zeros_even > sampled / 6 && zeros_odd < sampled / 30) begin
        v.encoding_kind = KIND_UTF16BE;
        v.is_utf16      = 1'b1;
      end else begin
        decided = 1'b0;
      end
      if (!decided) begin
        v.encoding_kind = (sampled >= 4 && head_bytes == BOM32_BE) ? KIND_UTF32BE
                                                                   : KIND_UNKNOWN;
      end
      v.has_non_ascii = saw_high;
      if (!v.is_utf16)
        v.is_binary = saw_null || (longint'(ctrl_bytes) * 10 > longint'(sampled) * 3);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic in_t make_item(input logic [7:0] b, input bit valid, input bit eof);
    in_t it;
    it.data_byte   = b;
    it.byte_valid  = valid;
    it.end_of_file = eof;
    return it;
  endfunction

  // one input transaction; called at a rising edge, returns at the edge that
  // accepted it, with in_valid still high
  task automatic send_item(input in_t item);
    if (idling) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.byte_valid) absorb_byte(item.data_byte);
    if (item.end_of_file) begin
      pending_verdicts.push_back(predict_verdict());
      clear_stats();
    end
    items_sent++;
  endtask

  // bytes of one file; the end of file rides on the last byte or on a
  // separate item without a byte
  task automatic send_file(input byte_q_t body, input bit eof_alone, input int noise_pct);
    int last;
    last = body.size() - 1;
    foreach (body[i]) begin
      if ($urandom_range(99) < noise_pct)
        send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
      send_item(make_item(body[i], 1'b1, !eof_alone && i == last));
    end
    if (eof_alone || body.size() == 0)
      send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
    file_index++;
  endtask

  // hold the input off until every verdict has come back
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= idling ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [2:0] got,
                             input logic [2:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", what, got, want));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict with no file pending");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("encoding_kind", out_data.encoding_kind, want.encoding_kind);
        check_field("is_binary", 3'(out_data.is_binary), 3'(want.is_binary));
        check_field("has_non_ascii", 3'(out_data.has_non_ascii), 3'(want.has_non_ascii));
        check_field("is_utf8", 3'(out_data.is_utf8), 3'(want.is_utf8));
        check_field("is_utf16", 3'(out_data.is_utf16), 3'(want.is_utf16));
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL text_encoding_sniffer_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] text_byte();
    case ($urandom_range(9))
      0:       return CHR_LF;
      1:       return CHR_TAB;
      2:       return CHR_CR;
      default: return 8'($urandom_range(CHR_SPACE, CHR_TILDE));
    endcase
  endfunction

  task automatic test_empty_file();
    byte_q_t body;
    body = {};
    send_file(body, 1'b1, 0);
  endtask

  // full bom, then a bom cut short by the end of file
  task automatic test_utf8_bom();
    send_file({BOM8_B0, BOM8_B1, BOM8_B2, 8'hFF}, 1'b0, 0);
    send_file({BOM8_B0, BOM8_B1}, 1'b0, 0);
  endtask

  // utf-16le bom followed by two zeros is still utf-16le
  task automatic test_utf16_boms();
    send_file({BOM16_FF, BOM16_FE, CHR_NUL, CHR_NUL}, 1'b0, 0);
    send_file({BOM16_FE, BOM16_FF}, 1'b0, 0);
  endtask

  task automatic test_utf32_bom();
    send_file({BOM32_BE[31:24], BOM32_BE[23:16], BOM32_BE[15:8], BOM32_BE[7:0]},
              1'b0, 0);
  endtask

  // zero-majority guess needs at least thirty bytes for the quiet lane
  task automatic test_zero_majority();
    byte_q_t body;
    body = {};
    repeat (15) begin
      body.push_back(text_byte());
      body.push_back(CHR_NUL);
    end
    send_file(body, 1'b1, 0);
  endtask

  // control bytes above the threshold, with an ignored item in between
  task automatic test_control_bytes();
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    send_file({8'h01, CHR_DEL, CHR_SPACE}, 1'b0, 0);
  endtask

  task automatic test_random_files();
    byte_q_t body;
    int      len;
    int      first_file;
    first_file = file_index;
    while (items_sent < RANDOM_ITEMS) begin
      body = {};
      len  = ($urandom_range(39) == 0) ? $urandom_range(400) : $urandom_range(40);
      case ($urandom_range(7))
        0: repeat (len) body.push_back(text_byte());
        1: begin
          if ($urandom_range(1)) body = {BOM16_FF, BOM16_FE};
          repeat ($urandom_range(15, 60)) begin
            body.push_back(($urandom_range(19) == 0) ? CHR_NUL : text_byte());
            body.push_back(($urandom_range(19) == 0) ? text_byte() : CHR_NUL);
          end
        end
        2: begin
          if ($urandom_range(1)) body = {BOM16_FE, BOM16_FF};
          repeat ($urandom_range(15, 60)) begin
            body.push_back(($urandom_range(19) == 0) ? text_byte() : CHR_NUL);
            body.push_back(($urandom_range(19) == 0) ? CHR_NUL : text_byte());
          end
        end
        3: begin
          body = {BOM8_B0, BOM8_B1, BOM8_B2};
          repeat (len)
            body.push_back($urandom_range(3) == 0 ? 8'($urandom_range(CHR_HIGH, 8'hFF))
                                                  : text_byte());
        end
        4: repeat (len) body.push_back(8'($urandom_range(255)));
        5: repeat (len)
             body.push_back($urandom_range(1) ? 8'($urandom_range(1, 31)) : text_byte());
        6: begin
          body = {BOM32_BE[31:24], BOM32_BE[23:16], BOM32_BE[15:8], BOM32_BE[7:0]};
          repeat (len) body.push_back(8'($urandom_range(255)));
        end
        default: begin
          // short files around the bom patterns
          repeat ($urandom_range(4)) begin
            case ($urandom_range(6))
              0: body.push_back(CHR_NUL);
              1: body.push_back(BOM8_B0);
              2: body.push_back(BOM8_B1);
              3: body.push_back(BOM8_B2);
              4: body.push_back(BOM16_FE);
              5: body.push_back(BOM16_FF);
              default: body.push_back(8'($urandom_range(255)));
            endcase
          end
        end
      endcase
      // a stretch of files with no idling on either side
      idling = !(file_index - first_file >= 20 && file_index - first_file < 32);
      if (file_index - first_file == 15) wait_for_verdicts();
      send_file(body, $urandom_range(4) == 0, 10);
    end
    idling = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count = 0;
    file_index  = 0;
    items_sent  = 0;
    clear_stats();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_file();
    test_utf8_bom();
    test_utf16_boms();
    test_utf32_bom();
    test_zero_majority();
    test_control_bytes();
    test_random_files();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never came", pending_verdicts.size()));

    if (error_count == 0) $display("PASS text_encoding_sniffer_core");
    else $display("FAIL text_encoding_sniffer_core");
    $finish;
  end

endmodule
